// File: hdl/itp_pkg.sv
package itp_pkg;

	typedef struct packed {
		logic [9:0] count;
		logic       start_req;
	} item_t;

	typedef struct packed {
		logic [10:0] value;
		logic        error;
	} result_t;

	localparam int unsigned CfgWidth = 11;

endpackage

// File: hdl/itp_mem.sv
module itp_mem #(
	parameter int AW = 11,
	parameter int DW = 11
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [2**AW];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: hdl/itp_step.sv
// One tree level: live count of the right child, then pick a side.
module itp_step #(
	parameter int CW = 11
) (
	input  logic [CW-1:0] n,
	input  logic [CW-1:0] lo,
	input  logic [CW-1:0] half,
	input  logic [CW-1:0] k,
	input  logic [CW-1:0] par_removed,
	input  logic [CW-1:0] right_removed,
	output logic          go_right,
	output logic [CW-1:0] k_next,
	output logic [CW-1:0] child_removed
);

	logic [CW-1:0] right_lo;
	logic [CW-1:0] diff;
	logic [CW-1:0] full;
	logic [CW-1:0] right_cnt;

	always_comb begin
		right_lo  = lo + half;
		diff      = n - right_lo;
		// values in [right_lo, right_lo + half) that belong to the full set
		if (n <= right_lo) begin
			full = '0;
		end else if (diff > half) begin
			full = half;
		end else begin
			full = diff;
		end
		right_cnt     = full - right_removed;
		go_right      = (right_cnt >= k);
		k_next        = go_right ? k : (k - right_cnt);
		child_removed = go_right ? right_removed : (par_removed - right_removed);
	end

endmodule

// File: hdl/inversion_table_to_permutation.sv
// Channel  Direction  Handshake                  Payload
// item     in         item_valid / item_stall    itp_pkg::item_t   (count, start_req)
// result   out        result_valid / result_stall itp_pkg::result_t (value, error)
// cfg      in         cfg_we                     cfg_data = used_size
//
// An item passes a check step (repeated with start_req, after a sweep if the tree is dirty)
// and, unless an out-of-range count returns an error, a descent over the tree levels on
// the single node-count RAM port pair, then loads the output register as item_stall drops.
// The tree RAM holds removed counts per node; after reset, and on a refill once any value
// has been taken, all 2 * 2**ceil(log2(MAX_VALUES)) words (2048 at 1024) are swept to zero
// with item_stall high. A stalled result holds in the output register; the next item may transfer meanwhile.
module inversion_table_to_permutation #(
	parameter int MAX_VALUES = 1024
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       item_valid,
	output logic                       item_stall,
	input  itp_pkg::item_t             item,
	output logic                       result_valid,
	input  logic                       result_stall,
	output itp_pkg::result_t           result,
	input  logic                       cfg_we,
	input  logic [itp_pkg::CfgWidth-1:0] cfg_data
);

	import itp_pkg::*;

	localparam int LW     = (MAX_VALUES > 1) ? $clog2(MAX_VALUES) : 1;
	localparam int LEAF   = 1 << LW;
	localparam int AW     = LW + 1;
	localparam int CW     = LW + 1;
	localparam int RST_N  = (MAX_VALUES < 1024) ? MAX_VALUES : 1024;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_CHECK = 3'd1;
	localparam logic [2:0] ST_DESC  = 3'd2;
	localparam logic [2:0] ST_DONE  = 3'd3;
	localparam logic [2:0] ST_CLEAR = 3'd4;

	logic [2:0]    state_q;
	logic [9:0]    count_q;
	logic          start_q;
	logic          pend_q;
	logic          dirty_q;
	logic [CW-1:0] n_q;
	logic [CW-1:0] remaining_q;
	logic [AW-1:0] node_q;
	logic [CW-1:0] lo_q;
	logic [CW-1:0] half_q;
	logic [CW-1:0] k_q;
	logic [CW-1:0] prem_q;
	logic [AW-1:0] clr_q;
	result_t       res_q;
	result_t       out_q;
	logic          out_valid_q;

	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [CW-1:0] mem_wdata;
	logic [AW-1:0] mem_raddr;
	logic [CW-1:0] mem_rdata;

	logic          go_right;
	logic [CW-1:0] k_next;
	logic [CW-1:0] child_removed;
	logic [AW-1:0] child;
	logic [CW-1:0] picked;
	logic [CW-1:0] cfg_n;
	logic          item_xfer;
	logic          out_free;

	itp_mem #(
		.AW (AW),
		.DW (CW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	itp_step #(
		.CW (CW)
	) u_step (
		.n             (n_q),
		.lo            (lo_q),
		.half          (half_q),
		.k             (k_q),
		.par_removed   (prem_q),
		.right_removed (mem_rdata),
		.go_right      (go_right),
		.k_next        (k_next),
		.child_removed (child_removed)
	);

	always_comb begin
		child     = {node_q[AW-2:0], go_right};
		picked    = go_right ? (lo_q + half_q) : lo_q;
		item_xfer = item_valid && !item_stall;
		out_free  = !out_valid_q || !result_stall;
		if (32'(cfg_data) > 32'(MAX_VALUES)) begin
			cfg_n = CW'(MAX_VALUES);
		end else begin
			cfg_n = CW'(cfg_data);
		end
	end

	// single RAM port pair: sweep writes, or one level's update + next read
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = child;
		mem_wdata = child_removed + CW'(1);
		mem_raddr = {child[AW-2:0], 1'b1};
		unique case (state_q)
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				mem_wdata = '0;
			end
			ST_CHECK: begin
				mem_raddr = AW'(3);
			end
			ST_DESC: begin
				mem_we = 1'b1;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			pend_q      <= 1'b0;
			start_q     <= 1'b0;
			dirty_q     <= 1'b1;
			n_q         <= CW'(RST_N);
			remaining_q <= CW'(RST_N);
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_DONE && out_free) begin
				out_q       <= res_q;
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (item_xfer) begin
						count_q <= item.count;
						start_q <= item.start_req;
						pend_q  <= 1'b1;
					end
					// register write refills the set; only taken while idle or sweeping
					if (cfg_we) begin
						n_q         <= cfg_n;
						remaining_q <= cfg_n;
					end
					if (cfg_we && dirty_q) begin
						clr_q   <= '0;
						state_q <= ST_CLEAR;
					end else if (item_xfer) begin
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					if (start_q) begin
						start_q     <= 1'b0;
						remaining_q <= n_q;
						if (dirty_q) begin
							clr_q   <= '0;
							state_q <= ST_CLEAR;
						end
					end else if (32'(count_q) >= 32'(remaining_q)) begin
						res_q.value <= '0;
						res_q.error <= 1'b1;
						state_q     <= ST_DONE;
					end else begin
						node_q  <= AW'(1);
						lo_q    <= '0;
						half_q  <= CW'(LEAF / 2);
						k_q     <= CW'(count_q) + CW'(1);
						prem_q  <= n_q - remaining_q;
						state_q <= ST_DESC;
					end
				end
				ST_DESC: begin
					dirty_q <= 1'b1;
					if (half_q == CW'(1)) begin
						res_q.value <= 11'(picked + CW'(1));
						res_q.error <= 1'b0;
						remaining_q <= remaining_q - CW'(1);
						state_q     <= ST_DONE;
					end else begin
						node_q <= child;
						lo_q   <= picked;
						half_q <= half_q >> 1;
						k_q    <= k_next;
						prem_q <= child_removed;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						pend_q  <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				ST_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == '1) begin
						dirty_q <= 1'b0;
						state_q <= pend_q ? ST_CHECK : ST_IDLE;
					end
					if (cfg_we) begin
						n_q         <= cfg_n;
						remaining_q <= cfg_n;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign item_stall   = (state_q != ST_IDLE);
	assign result_valid = out_valid_q;
	assign result       = out_q;

endmodule

// File: verif/tb_top.sv
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import itp_pkg::*;

	localparam int MaxValues = 1024;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        item_valid = 1'b0;
	logic        item_stall;
	item_t       item = '0;
	logic        result_valid;
	logic        result_stall = 1'b0;
	result_t     result;
	logic        cfg_we = 1'b0;
	logic [CfgWidth-1:0] cfg_data = '0;

	// predicted decoder state
	logic [10:0] size_reg;
	bit          in_set [MaxValues];
	int unsigned values_left;
	result_t     decoded_queue [$];

	int unsigned fail_count = 0;
	int unsigned burst_left = 0;
	int unsigned stall_mode = 0;
	int unsigned stall_left = 0;

	inversion_table_to_permutation #(.MAX_VALUES(MaxValues)) uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_we       (cfg_we),
		.cfg_data     (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int unsigned effective_size();
		return (size_reg > MaxValues) ? MaxValues : int'(size_reg);
	endfunction

	function automatic void refill_value_set();
		int unsigned n;
		n = effective_size();
		for (int i = 0; i < MaxValues; i++) begin
			in_set[i] = (i < n);
		end
		values_left = n;
	endfunction

	// k-th largest unused value, k = count + 1; an oversized count leaves the set alone
	function automatic result_t decode_entry(input item_t it);
		result_t     r;
		int unsigned k;
		int          v;
		if (it.start_req) refill_value_set();
		r = '0;
		if (32'(it.count) >= values_left) begin
			r.error = 1'b1;
			return r;
		end
		k = 32'(it.count) + 1;
		for (v = MaxValues - 1; v >= 0; v--) begin
			if (in_set[v]) begin
				k--;
				if (k == 0) break;
			end
		end
		in_set[v] = 1'b0;
		values_left--;
		r.value = 11'(v + 1);
		return r;
	endfunction

	// result checker
	always @(posedge clk) begin : check_results
		result_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (decoded_queue.size() == 0) begin
				fail_count++;
				if (fail_count <= 10)
					$display("unexpected result: value %0d error %0b", result.value, result.error);
			end else begin
				want = decoded_queue.pop_front();
				if (result.value !== want.value || result.error !== want.error) begin
					fail_count++;
					if (fail_count <= 10)
						$display("mismatch: expected value %0d error %0b, got value %0d error %0b",
							want.value, want.error, result.value, result.error);
				end
			end
		end
	end

	// receiver back-pressure: a randomly chosen stall mode, redrawn whenever its random run ends
	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_mode = $urandom_range(0, 3);
			stall_left = $urandom_range(20, 200);
		end else begin
			stall_left--;
		end
		case (stall_mode)
			0: result_stall <= 1'b0;
			1: result_stall <= ($urandom_range(0, 3) == 0);
			2: result_stall <= ($urandom_range(0, 3) != 0);
			default: result_stall <= (stall_left[2:0] < 3);
		endcase
	end

	// one transfer on the item channel; called at a rising edge
	task automatic feed(input logic [9:0] cnt, input logic start);
		int unsigned gap;
		item_t       it;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			case ($urandom_range(0, 3))
				0: gap = 0;
				1: gap = 1;
				2: gap = $urandom_range(2, 6);
				default: gap = $urandom_range(7, 30);
			endcase
			if (gap != 0) begin
				item_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		it.count = cnt;
		it.start_req = start;
		item_valid <= 1'b1;
		item <= it;
		do @(posedge clk); while (item_stall);
		decoded_queue.push_back(decode_entry(it));
	endtask

	task automatic wait_all_results();
		item_valid <= 1'b0;
		while (decoded_queue.size() != 0) @(posedge clk);
	endtask

	task automatic program_size(input logic [10:0] sz);
		wait_all_results();
		while (item_stall) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_data <= sz;
		@(posedge clk);
		cfg_we <= 1'b0;
		size_reg = sz;
		refill_value_set();
	endtask

	// reset leaves a full set of 1024 values
	task automatic test_reset_state();
		feed(10'd1023, 1'b0);
		feed(10'd0, 1'b0);
		feed(10'd1022, 1'b0);
		feed(10'd1021, 1'b0);
		feed(10'd0, 1'b1);
	endtask

	// tiny, empty and saturated sizes, exhausted set, refill
	task automatic test_size_limits();
		program_size(11'd1);
		feed(10'd0, 1'b0);
		feed(10'd0, 1'b0);
		feed(10'd1023, 1'b0);
		feed(10'd0, 1'b1);
		program_size(11'd0);
		feed(10'd0, 1'b0);
		feed(10'd0, 1'b1);
		program_size(11'd2047);
		feed(10'd1023, 1'b1);
		feed(10'd0, 1'b0);
		program_size(11'd2);
		feed(10'd1, 1'b0);
		feed(10'd1, 1'b0);
		feed(10'd0, 1'b0);
		feed(10'd0, 1'b0);
	endtask

	// mostly valid inversion tables with random entries, plus noise and broken runs
	task automatic decode_sequence(input int unsigned len);
		int unsigned rem;
		logic [9:0]  c;
		logic        st;
		for (int unsigned i = 0; i < len; i++) begin
			st = (i == 0) && ($urandom_range(0, 9) != 0);
			rem = st ? effective_size() : values_left;
			if ($urandom_range(0, 24) == 0) begin
				c = 10'($urandom_range(0, 1023));
				st = ($urandom_range(0, 7) == 0);
			end else if (rem == 0) begin
				c = 10'($urandom_range(0, 1023));
			end else begin
				case ($urandom_range(0, 3))
					0: c = 10'd0;
					1: c = 10'(rem - 1);
					default: c = 10'($urandom_range(0, rem - 1));
				endcase
			end
			if (i == len / 2 && $urandom_range(0, 9) == 0) wait_all_results();
			feed(c, st);
		end
	endtask

	task automatic test_random_decoding();
		int unsigned sent;
		int unsigned pick;
		int unsigned nseq;
		int unsigned len;
		logic [10:0] sz;
		sent = 0;
		while (sent < 1080) begin
			pick = $urandom_range(0, 19);
			if (pick == 0) sz = 11'd1024;
			else if (pick == 1) sz = 11'($urandom_range(1025, 2047));
			else if (pick == 2) sz = 11'd0;
			else if (pick < 7) sz = 11'($urandom_range(1, 4));
			else sz = 11'($urandom_range(5, 60));
			program_size(sz);
			nseq = $urandom_range(1, 4);
			for (int unsigned s = 0; s < nseq; s++) begin
				if (effective_size() == 0) begin
					len = $urandom_range(1, 3);
				end else if (effective_size() > 200) begin
					len = $urandom_range(30, 100);
				end else begin
					len = effective_size();
					case ($urandom_range(0, 7))
						0: len += $urandom_range(1, 3);
						1: len = $urandom_range(1, len);
						default: ;
					endcase
				end
				decode_sequence(len);
				sent += len;
			end
		end
	endtask

	initial begin
		size_reg = 11'd1024;
		refill_value_set();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_state();
		test_size_limits();
		test_random_decoding();
		wait_all_results();
		repeat (30) @(posedge clk);
		if (fail_count == 0) begin
			$display("tb_top: done, clean");
		end else begin
			$display("tb_top: done, errors");
		end
		$finish;
	end

	initial begin
		#(100_000_000);
		$display("tb_top: done, errors");
		$finish;
	end

endmodule
